@@ sv/radix_converter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Radix converter assertion macros
// Concurrent assertion helpers used by the radix converter top level.
// ----------------------------------------------------------------------------
`ifndef RADIX_CONVERTER_UNIT_ASSERT_SVH
`define RADIX_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RCU_ASSERT_IMP(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");

`define RCU_ASSERT_NEXT(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");

`else

`define RCU_ASSERT_IMP(lbl, clk, rst, ant, cons)

`define RCU_ASSERT_NEXT(lbl, clk, rst, ant, cons)

`endif

`endif

@@ sv/rcu_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix converter package
// Widths, character codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package rcu_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int MAX_DIGITS     = 32;
  localparam int RADIX_BITS     = 5;
  localparam int DIGIT_BITS     = 4;
  localparam int CHAR_BITS      = 8;
  localparam int OUT_CHAR_BITS  = 7;
  localparam int CFG_INDEX_BITS = 2;
  localparam int ADDR_BITS      = $clog2(MAX_DIGITS);
  localparam int COUNT_BITS     = $clog2(MAX_DIGITS + 1);
  localparam int SHIFT_CNT_BITS = $clog2(VALUE_BITS);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_RADIX = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_RADIX = 2'd1;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 4'd10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic again;
  } div_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic                  quo_zero;
    logic [DIGIT_BITS-1:0] digit;
  } div_stat_t;

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [VALUE_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
    logic [VALUE_BITS-1:0] res;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      res = VALUE_BITS'(c - CHAR_LOWER_A) + VALUE_BITS'(DIGIT_TEN);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      res = VALUE_BITS'(c - CHAR_UPPER_A) + VALUE_BITS'(DIGIT_TEN);
    end else begin
      res = VALUE_BITS'(c) - VALUE_BITS'(CHAR_ZERO);
    end
    return res;
  endfunction

  function automatic logic [OUT_CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
    logic [OUT_CHAR_BITS-1:0] res;
    if (d < DIGIT_TEN) begin
      res = OUT_CHAR_BITS'(CHAR_ZERO) + OUT_CHAR_BITS'(d);
    end else begin
      res = OUT_CHAR_BITS'(CHAR_UPPER_A) + OUT_CHAR_BITS'(d - DIGIT_TEN);
    end
    return res;
  endfunction

endpackage

@@ sv/rcu_ram.sv @@
// ----------------------------------------------------------------------------
// Radix converter RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rcu_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rcu_accum.sv @@
// ----------------------------------------------------------------------------
// Radix converter accumulator
// Decodes each character and folds it into the running value.
// ----------------------------------------------------------------------------
module rcu_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               last_char,
  input  logic [rcu_pkg::CHAR_BITS-1:0]      digit_char,
  input  logic [rcu_pkg::RADIX_BITS-1:0]     source_radix,
  output logic [rcu_pkg::VALUE_BITS-1:0]     value_next
);

  localparam int PROD_BITS = rcu_pkg::VALUE_BITS + rcu_pkg::RADIX_BITS;

  logic [rcu_pkg::VALUE_BITS-1:0] acc;
  logic [PROD_BITS-1:0]           prod;

  assign prod = PROD_BITS'(acc) * PROD_BITS'(rcu_pkg::clamp_radix(source_radix));
  assign value_next = prod[rcu_pkg::VALUE_BITS-1:0] + rcu_pkg::char_value(digit_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= last_char ? '0 : value_next;
    end
  end

endmodule

@@ sv/rcu_divider.sv @@
// ----------------------------------------------------------------------------
// Radix converter divider
// Bit-serial restoring division of the value by the target radix.
// ----------------------------------------------------------------------------
module rcu_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  rcu_pkg::div_ctrl_t             ctrl,
  input  logic [rcu_pkg::VALUE_BITS-1:0] dividend,
  input  logic [rcu_pkg::RADIX_BITS-1:0] divisor,
  output rcu_pkg::div_stat_t             stat
);

  logic [rcu_pkg::VALUE_BITS-1:0]     quo;
  logic [rcu_pkg::RADIX_BITS-1:0]     rem;
  logic [rcu_pkg::RADIX_BITS-1:0]     dvs;
  logic [rcu_pkg::SHIFT_CNT_BITS-1:0] cnt;
  logic                               busy;
  logic                               done;
  logic [rcu_pkg::RADIX_BITS-1:0]     trial;
  logic                               ge;

  assign trial = {rem[rcu_pkg::DIGIT_BITS-1:0], quo[rcu_pkg::VALUE_BITS-1]};
  assign ge    = (trial >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (ctrl.load || ctrl.again) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo <= dividend;
      dvs <= rcu_pkg::clamp_radix(divisor);
      rem <= '0;
      cnt <= rcu_pkg::SHIFT_CNT_BITS'(rcu_pkg::VALUE_BITS - 1);
    end else if (ctrl.again) begin
      rem <= '0;
      cnt <= rcu_pkg::SHIFT_CNT_BITS'(rcu_pkg::VALUE_BITS - 1);
    end else if (busy) begin
      rem <= ge ? trial - dvs : trial;
      quo <= {quo[rcu_pkg::VALUE_BITS-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.done     = done;
  assign stat.quo_zero = (quo == '0);
  assign stat.digit    = rem[rcu_pkg::DIGIT_BITS-1:0];

endmodule

@@ sv/radix_converter_unit.sv @@
// ----------------------------------------------------------------------------
// Radix converter unit
// Accumulates digit characters and writes the value out in another radix.
// ----------------------------------------------------------------------------
// A character that is not marked last is folded into the running value. The
// last character starts the conversion: each output digit is produced by a
// bit-serial divider, and the digits are then read back from the digit RAM
// most significant first, each digit read (S_READ) and then presented
// (S_OUT) until the output is not stalled. No new character is taken until
// the final digit of a number has been delivered.
`include "radix_converter_unit_assert.svh"

module radix_converter_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rcu_pkg::CHAR_BITS-1:0]         digit_char,
  input  logic                                  last_char,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rcu_pkg::OUT_CHAR_BITS-1:0]     out_char,
  output logic                                  end_of_number,
  input  logic                                  cfg_we,
  input  logic [rcu_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rcu_pkg::RADIX_BITS-1:0]        cfg_data
);

  rcu_pkg::state_t                  state;
  rcu_pkg::state_t                  state_next;
  logic [rcu_pkg::COUNT_BITS-1:0]   count;
  logic [rcu_pkg::COUNT_BITS-1:0]   count_next;
  logic                             eon;
  logic                             eon_next;
  logic [rcu_pkg::RADIX_BITS-1:0]   source_radix;
  logic [rcu_pkg::RADIX_BITS-1:0]   target_radix;
  logic [rcu_pkg::VALUE_BITS-1:0]   value_next;
  logic                             in_accept;
  rcu_pkg::div_ctrl_t               dctrl;
  rcu_pkg::div_stat_t               dstat;
  logic                             ram_we;
  logic                             ram_re;
  logic [rcu_pkg::ADDR_BITS-1:0]    ram_raddr;
  logic [rcu_pkg::DIGIT_BITS-1:0]   ram_rdata;

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_radix <= rcu_pkg::RADIX_RESET;
      target_radix <= rcu_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rcu_pkg::REG_SOURCE_RADIX: source_radix <= cfg_data;
        rcu_pkg::REG_TARGET_RADIX: target_radix <= cfg_data;
        default: ;
      endcase
    end
  end

  rcu_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .last_char    (last_char),
    .digit_char   (digit_char),
    .source_radix (source_radix),
    .value_next   (value_next)
  );

  rcu_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dctrl),
    .dividend (value_next),
    .divisor  (target_radix),
    .stat     (dstat)
  );

  rcu_ram #(
    .WIDTH (rcu_pkg::DIGIT_BITS),
    .DEPTH (rcu_pkg::MAX_DIGITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[rcu_pkg::ADDR_BITS-1:0]),
    .wdata (dstat.digit),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcu_pkg::S_IDLE;
      count <= '0;
      eon   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      eon   <= eon_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    eon_next    = eon;
    dctrl.load  = 1'b0;
    dctrl.again = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rcu_pkg::ADDR_BITS'(count - 1'b1);
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state)
      rcu_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && last_char) begin
          dctrl.load = 1'b1;
          count_next = '0;
          state_next = rcu_pkg::S_DIV;
        end
      end
      rcu_pkg::S_DIV: begin
        if (dstat.done) begin
          if (count < rcu_pkg::COUNT_BITS'(rcu_pkg::MAX_DIGITS)) begin
            ram_we     = 1'b1;
            count_next = count + 1'b1;
          end
          if (dstat.quo_zero) begin
            state_next = rcu_pkg::S_READ;
          end else begin
            dctrl.again = 1'b1;
          end
        end
      end
      rcu_pkg::S_READ: begin
        ram_re     = 1'b1;
        count_next = count - 1'b1;
        eon_next   = (count == rcu_pkg::COUNT_BITS'(1));
        state_next = rcu_pkg::S_OUT;
      end
      rcu_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = eon ? rcu_pkg::S_IDLE : rcu_pkg::S_READ;
        end
      end
      default: begin
        state_next = rcu_pkg::S_IDLE;
      end
    endcase
  end

  assign out_char      = rcu_pkg::digit_to_char(ram_rdata);
  assign end_of_number = eon;

  `RCU_ASSERT_IMP(a_no_input_while_output, clk, rst, out_valid, in_stall)
  `RCU_ASSERT_IMP(a_done_in_div, clk, rst, dstat.done, state == rcu_pkg::S_DIV)
  `RCU_ASSERT_NEXT(a_read_then_out, clk, rst, state == rcu_pkg::S_READ, out_valid)
  `RCU_ASSERT_IMP(a_count_range, clk, rst, 1'b1,
                  count <= rcu_pkg::COUNT_BITS'(rcu_pkg::MAX_DIGITS))

endmodule

@@ tb/sv/tb_radix_converter_unit.sv @@
// ----------------------------------------------------------------------------
// Radix converter unit testbench
// Sends digit strings in a source radix and checks every emitted digit in the
// target radix against a predictor running alongside, under random input
// gaps and output stalls, across several radix settings.
// ----------------------------------------------------------------------------
module tb_radix_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rcu_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [OUT_CHAR_BITS-1:0] ch;
    logic                     eon;
  } digit_out_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [CHAR_BITS-1:0]      digit_char;
  logic                      last_char;
  logic                      out_valid;
  logic                      out_stall;
  logic [OUT_CHAR_BITS-1:0]  out_char;
  logic                      end_of_number;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [RADIX_BITS-1:0]     cfg_data;

  logic [VALUE_BITS-1:0] acc_value;
  logic [RADIX_BITS-1:0] src_radix;
  logic [RADIX_BITS-1:0] tgt_radix;
  digit_out_t            expected_digits[$];
  int                    mismatches;
  int                    sent_items;
  int                    cycles;
  bit                    src_idle_en;
  bit                    sink_idle_en;

  radix_converter_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .digit_char   (digit_char),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .end_of_number(end_of_number),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [RADIX_BITS-1:0] effective_radix(input logic [RADIX_BITS-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] char_weight(input logic [CHAR_BITS-1:0] c);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      return VALUE_BITS'(c - CHAR_LOWER_A) + VALUE_BITS'(DIGIT_TEN);
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      return VALUE_BITS'(c - CHAR_UPPER_A) + VALUE_BITS'(DIGIT_TEN);
    end
    return VALUE_BITS'(c) - VALUE_BITS'(CHAR_ZERO);
  endfunction

  function automatic logic [OUT_CHAR_BITS-1:0] digit_glyph(input logic [DIGIT_BITS-1:0] d);
    if (d < DIGIT_TEN) return OUT_CHAR_BITS'(CHAR_ZERO) + OUT_CHAR_BITS'(d);
    return OUT_CHAR_BITS'(CHAR_UPPER_A) + OUT_CHAR_BITS'(d - DIGIT_TEN);
  endfunction

  function automatic logic [CHAR_BITS-1:0] rand_digit_char(input logic [RADIX_BITS-1:0] r);
    int unsigned d;
    d = $urandom_range(0, int'(r) - 1);
    if (d < 10) return CHAR_ZERO + CHAR_BITS'(d);
    if ($urandom_range(0, 1) == 0) return CHAR_LOWER_A + CHAR_BITS'(d - 10);
    return CHAR_UPPER_A + CHAR_BITS'(d - 10);
  endfunction

  // Folds one accepted character into the running value and, on the last
  // character, queues the digits of the value in the target radix.
  task automatic fold_char(input logic [CHAR_BITS-1:0] c, input logic last);
    logic [VALUE_BITS-1:0] v;
    logic [RADIX_BITS-1:0] tr;
    logic [DIGIT_BITS-1:0] digits[MAX_DIGITS];
    int                    n;
    int                    i;
    acc_value = acc_value * effective_radix(src_radix) + char_weight(c);
    if (last) begin
      v  = acc_value;
      tr = effective_radix(tgt_radix);
      n  = 0;
      do begin
        if (n < MAX_DIGITS) begin
          digits[n] = DIGIT_BITS'(v % tr);
          n++;
        end
        v = v / tr;
      end while (v != 0);
      for (i = n - 1; i >= 0; i--) begin
        expected_digits.push_back('{ch: digit_glyph(digits[i]), eon: (i == 0)});
      end
      acc_value = '0;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [RADIX_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_SOURCE_RADIX) begin
      src_radix = data;
    end else if (idx == REG_TARGET_RADIX) begin
      tgt_radix = data;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic last);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    digit_char <= c;
    last_char  <= last;
    do @(posedge clk); while (in_stall);
    fold_char(c, last);
    sent_items++;
  endtask

  // A character that causes no output is folded in at its accepting edge.
  // The extra wait after the last digit only leaves the block idle before the
  // next register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic test_zero();
    send_string("0");
    wait_idle();
  endtask

  task automatic test_letters();
    write_reg(REG_SOURCE_RADIX, 5'd16);
    write_reg(REG_TARGET_RADIX, 5'd10);
    send_string("aFfA");
    wait_idle();
  endtask

  task automatic test_widest_value();
    write_reg(REG_TARGET_RADIX, 5'd2);
    send_string("ffffffffF");
    wait_idle();
  endtask

  task automatic test_odd_chars();
    write_reg(REG_SOURCE_RADIX, 5'd2);
    write_reg(REG_TARGET_RADIX, 5'd16);
    send_char(8'h00, 1'b0);
    send_char("9", 1'b0);
    send_char(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_radix_clamp();
    write_reg(REG_SOURCE_RADIX, 5'd0);
    write_reg(REG_TARGET_RADIX, 5'd31);
    send_string("11");
    wait_idle();
    write_reg(REG_SOURCE_RADIX, 5'd17);
    write_reg(REG_TARGET_RADIX, 5'd1);
    send_string("f");
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_reg(REG_SOURCE_RADIX, 5'd10);
    write_reg(REG_TARGET_RADIX, 5'd10);
    write_reg(REG_SPARE_LO, 5'd3);
    write_reg(REG_SPARE_HI, 5'd31);
    send_string("12");
    wait_idle();
  endtask

  task automatic test_random_phase(input logic [RADIX_BITS-1:0] src,
                                   input logic [RADIX_BITS-1:0] tgt,
                                   input int count);
    int stop_at;
    int len;
    int i;
    write_reg(REG_SOURCE_RADIX, src);
    write_reg(REG_TARGET_RADIX, tgt);
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++) begin
          send_char(rand_digit_char(effective_radix(src_radix)), i == len - 1);
        end
      end else begin
        send_char(CHAR_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    wait_idle();
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    digit_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected transaction: out_char=%h end_of_number=%b",
                   out_char, end_of_number);
        end
      end else begin
        want = expected_digits.pop_front();
        if (out_char !== want.ch || end_of_number !== want.eon) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch: out_char exp %h got %h, end_of_number exp %b got %b",
                     want.ch, out_char, want.eon, end_of_number);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    digit_char   = '0;
    last_char    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    acc_value    = '0;
    src_radix    = RADIX_RESET;
    tgt_radix    = RADIX_RESET;
    mismatches   = 0;
    sent_items   = 0;
    cycles       = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_zero();
    test_letters();
    test_widest_value();
    test_odd_chars();
    test_radix_clamp();
    test_spare_index();

    test_random_phase(5'd10, 5'd16, 30);
    test_random_phase(5'd16, 5'd2, 30);
    test_random_phase(5'd2, 5'd16, 30);
    test_random_phase(5'd8, 5'd3, 30);
    test_random_phase(RADIX_BITS'($urandom_range(0, 31)), RADIX_BITS'($urandom_range(0, 31)), 30);
    test_random_phase(RADIX_BITS'($urandom_range(2, 16)), RADIX_BITS'($urandom_range(2, 16)), 30);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_phase(5'd16, 5'd10, 30);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
